### design/lpf_pkg.sv
// Shared constants, types and helper functions for the length-prefixed packet FIFO.
// No dependencies; imported by lpf_ram, length_prefixed_packet_fifo and the test bench.
package lpf_pkg;

    localparam int DEPTH = 64;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int CFG_W = 7;
    localparam int LW    = 6;
    localparam int BW    = 8;
    localparam int MW    = (CW > LW) ? CW + 1 : LW + 1;

    typedef enum logic [2:0] {
        F_START    = 3'd0,
        F_PUSH     = 3'd1,
        F_FINALIZE = 3'd2,
        F_ABORT    = 3'd3,
        F_POP      = 3'd4,
        F_CLEAR    = 3'd5
    } t_func;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_ERR   = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_HDR  = 3'b010,
        S_DATA = 3'b100
    } t_state;

    function automatic logic [CW-1:0] f_ring_size(input logic [CFG_W-1:0] v);
        logic [CFG_W-1:0] s;
        s = v;
        if (v < CFG_W'(2)) begin
            s = CFG_W'(2);
        end else if (v > CFG_W'(DEPTH)) begin
            s = CFG_W'(DEPTH);
        end
        return s[CW-1:0];
    endfunction

    function automatic logic [AW-1:0] f_advance(input logic [AW-1:0] p,
                                                input logic [CW-1:0] size);
        logic [CW:0] nx;
        nx = (CW + 1)'(p) + (CW + 1)'(1);
        return (nx >= (CW + 1)'(size)) ? '0 : nx[AW-1:0];
    endfunction

endpackage

### design/length_prefixed_packet_fifo.sv
// Length-prefixed packet FIFO top level: command decode, ring pointers and pop sequencer.
// Depends on lpf_pkg and lpf_ram.
//
// Usage:
//   Commands enter on start/i_func/i_data_byte and are taken at an edge where
//   start is high and busy is low. Every result shows on the o_ ports for one
//   cycle with o_valid high; the receiver cannot stall, so each result is taken
//   in that cycle. o_last marks the final result of a command.
//   Start, push, finalize, abort, clear and the unused codes give one result
//   the cycle after acceptance and keep busy low: one command per cycle.
//   Pop of a committed packet of N data bytes holds busy for one header read
//   from the ring memory, then one memory read per byte, and shows its bytes
//   on consecutive cycles, the first after the header state, the first data
//   state and the output register. A pop with nothing committed answers
//   next cycle with empty, and a pop of an empty packet after the header state.
//   The buffer size register is written on i_cfg_valid/o_cfg_ready while no
//   command is in flight; the write also empties the ring.
//   Synchronous reset empties the ring and sets the size to the full depth.
module length_prefixed_packet_fifo
    import lpf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [2:0]       i_func,
    input  logic [BW-1:0]    i_data_byte,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_buffer_size,
    output logic             o_valid,
    output logic [1:0]       o_status,
    output logic [BW-1:0]    o_out_byte,
    output logic [LW-1:0]    o_packet_length,
    output logic             o_last
);

    t_state        r_state, n_state;
    logic [CW-1:0] r_size, n_size;
    logic [AW-1:0] r_wptr, n_wptr;
    logic [AW-1:0] r_rptr, n_rptr;
    logic [AW-1:0] r_hpos, n_hpos;
    logic [CW-1:0] r_used, n_used;
    logic [CW-1:0] r_committed, n_committed;
    logic          r_open, n_open;
    logic [LW-1:0] r_olen, n_olen;
    logic [LW-1:0] r_plen, n_plen;
    logic [LW-1:0] r_left, n_left;

    logic          r_valid, n_valid;
    t_status       r_status, n_status;
    logic [BW-1:0] r_obyte, n_obyte;
    logic [LW-1:0] r_oplen, n_oplen;
    logic          r_olast, n_olast;

    logic          accept;
    logic          cfg_we;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [BW-1:0] wr_data;
    logic [BW-1:0] rd_data;
    logic          full;

    logic [LW-1:0] hdr_len;
    logic [MW-1:0] avail;
    logic [MW-1:0] pop_len_w;
    logic [MW-1:0] pop_take;
    logic [MW-1:0] used_after_pop;
    logic [MW-1:0] open_take;
    logic [MW-1:0] used_after_abort;

    lpf_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_raddr (n_rptr),
        .o_rdata (rd_data)
    );

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE) && !start;
    assign accept      = start && !busy;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;
    assign full        = (r_used >= r_size);

    assign hdr_len          = rd_data[LW-1:0];
    assign avail            = MW'(r_committed) - MW'(1);
    assign pop_len_w        = (MW'(hdr_len) > avail) ? avail : MW'(hdr_len);
    assign pop_take         = pop_len_w + MW'(1);
    assign used_after_pop   = (MW'(r_used) >= pop_take) ? MW'(r_used) - pop_take : '0;
    assign open_take        = MW'(r_olen) + MW'(1);
    assign used_after_abort = (MW'(r_used) >= open_take) ? MW'(r_used) - open_take : '0;

    always_comb begin
        n_state     = r_state;
        n_size      = r_size;
        n_wptr      = r_wptr;
        n_rptr      = r_rptr;
        n_hpos      = r_hpos;
        n_used      = r_used;
        n_committed = r_committed;
        n_open      = r_open;
        n_olen      = r_olen;
        n_plen      = r_plen;
        n_left      = r_left;
        n_valid     = 1'b0;
        n_status    = ST_OK;
        n_obyte     = '0;
        n_oplen     = '0;
        n_olast     = 1'b1;
        wr_en       = 1'b0;
        wr_addr     = r_wptr;
        wr_data     = i_data_byte;

        priority if (cfg_we) begin
            n_size      = f_ring_size(i_cfg_buffer_size);
            n_wptr      = '0;
            n_rptr      = '0;
            n_hpos      = '0;
            n_used      = '0;
            n_committed = '0;
            n_open      = 1'b0;
            n_olen      = '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        n_valid = 1'b1;
                        unique case (t_func'(i_func))
                            F_START: begin
                                if (r_open) begin
                                    n_status = ST_ERR;
                                end else if (full) begin
                                    n_status = ST_FULL;
                                end else begin
                                    n_hpos = r_wptr;
                                    n_wptr = f_advance(r_wptr, r_size);
                                    n_used = r_used + CW'(1);
                                    n_olen = '0;
                                    n_open = 1'b1;
                                end
                            end
                            F_PUSH: begin
                                if (!r_open) begin
                                    n_status = ST_ERR;
                                end else if (full) begin
                                    n_status = ST_FULL;
                                end else begin
                                    wr_en  = 1'b1;
                                    n_wptr = f_advance(r_wptr, r_size);
                                    n_used = r_used + CW'(1);
                                    n_olen = r_olen + LW'(1);
                                end
                            end
                            F_FINALIZE: begin
                                if (!r_open) begin
                                    n_status = ST_ERR;
                                end else begin
                                    wr_en       = 1'b1;
                                    wr_addr     = r_hpos;
                                    wr_data     = BW'(r_olen);
                                    n_committed = CW'(MW'(r_committed) + open_take);
                                    n_open      = 1'b0;
                                end
                            end
                            F_ABORT: begin
                                if (!r_open) begin
                                    n_status = ST_ERR;
                                end else begin
                                    n_wptr = r_hpos;
                                    n_used = CW'(used_after_abort);
                                    n_open = 1'b0;
                                    n_olen = '0;
                                end
                            end
                            F_POP: begin
                                if (r_committed == '0) begin
                                    n_status = ST_EMPTY;
                                end else begin
                                    n_valid = 1'b0;
                                    n_state = S_HDR;
                                end
                            end
                            F_CLEAR: begin
                                n_wptr      = '0;
                                n_rptr      = '0;
                                n_hpos      = '0;
                                n_used      = '0;
                                n_committed = '0;
                                n_open      = 1'b0;
                                n_olen      = '0;
                            end
                            default: begin
                                n_status = ST_OK;
                            end
                        endcase
                    end
                end
                S_HDR: begin
                    n_rptr      = f_advance(r_rptr, r_size);
                    n_committed = CW'(MW'(r_committed) - pop_take);
                    n_used      = CW'(used_after_pop);
                    n_plen      = pop_len_w[LW-1:0];
                    n_left      = pop_len_w[LW-1:0];
                    if (pop_len_w == '0) begin
                        n_valid = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_DATA;
                    end
                end
                S_DATA: begin
                    n_valid = 1'b1;
                    n_obyte = rd_data;
                    n_oplen = r_plen;
                    n_olast = (r_left == LW'(1));
                    n_rptr  = f_advance(r_rptr, r_size);
                    n_left  = r_left - LW'(1);
                    if (r_left == LW'(1)) begin
                        n_state = S_IDLE;
                    end
                end
                default: begin
                    n_state = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_size      <= CW'(DEPTH);
            r_wptr      <= '0;
            r_rptr      <= '0;
            r_hpos      <= '0;
            r_used      <= '0;
            r_committed <= '0;
            r_open      <= 1'b0;
            r_olen      <= '0;
            r_plen      <= '0;
            r_left      <= '0;
            r_valid     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_size      <= n_size;
            r_wptr      <= n_wptr;
            r_rptr      <= n_rptr;
            r_hpos      <= n_hpos;
            r_used      <= n_used;
            r_committed <= n_committed;
            r_open      <= n_open;
            r_olen      <= n_olen;
            r_plen      <= n_plen;
            r_left      <= n_left;
            r_valid     <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_obyte  <= n_obyte;
        r_oplen  <= n_oplen;
        r_olast  <= n_olast;
    end

    assign o_valid         = r_valid;
    assign o_status        = r_status;
    assign o_out_byte      = r_obyte;
    assign o_packet_length = r_oplen;
    assign o_last          = r_olast;

`ifndef NO_ASSERTIONS
    a_committed_le_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_committed <= r_used)
        else $error("committed byte count exceeds used byte count");

    a_used_le_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= r_size)
        else $error("used byte count exceeds ring size");

    a_mid_packet_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> (r_state == S_DATA))
        else $error("non-final pop byte shown outside data phase");

    a_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !cfg_we && (i_func == F_POP) && (r_committed == '0))
        |=> (o_valid && (o_status == ST_EMPTY) && o_last))
        else $error("pop with nothing committed did not report empty");
`endif

endmodule

### design/lpf_ram.sv
// Byte ring storage: one write port, one read port with registered read data.
// Depends on lpf_pkg for depth and widths.
module lpf_ram
    import lpf_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [BW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [BW-1:0] o_rdata
);

    logic [BW-1:0] r_mem [DEPTH];
    logic [BW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### verif/length_prefixed_packet_fifo_test.sv
`timescale 1ns / 1ps
// Self-checking bench for length_prefixed_packet_fifo: directed table, then random packet traffic.
// Depends on lpf_pkg and the length_prefixed_packet_fifo RTL, which also needs lpf_ram.
module length_prefixed_packet_fifo_test;
    import lpf_pkg::*;

    typedef struct packed {
        t_status       status;
        logic [BW-1:0] out_byte;
        logic [LW-1:0] pkt_length;
        logic          last;
    } t_fifo_word;

    typedef struct packed {
        logic          cfg_write;
        logic [2:0]    func;
        logic [BW-1:0] value;
        logic          fixed;
        t_fifo_word    word;
    } t_plan_row;

    localparam logic [2:0] F_SPARE6 = 3'd6;
    localparam logic [2:0] F_SPARE7 = 3'd7;
    localparam int         LIMIT    = 400000;
    localparam int         NROWS    = 29;
    localparam int         NPHASES  = 7;

    localparam t_fifo_word W_OK    = '{ST_OK, 8'h00, 6'd0, 1'b1};
    localparam t_fifo_word W_ERR   = '{ST_ERR, 8'h00, 6'd0, 1'b1};
    localparam t_fifo_word W_FULL  = '{ST_FULL, 8'h00, 6'd0, 1'b1};
    localparam t_fifo_word W_EMPTY = '{ST_EMPTY, 8'h00, 6'd0, 1'b1};
    localparam t_fifo_word W_NONE  = '0;

    localparam t_plan_row PLAN [0:NROWS-1] = '{
        '{1'b0, F_POP,      8'h00, 1'b1, W_EMPTY},
        '{1'b0, F_FINALIZE, 8'h00, 1'b1, W_ERR},
        '{1'b0, F_ABORT,    8'h00, 1'b1, W_ERR},
        '{1'b0, F_PUSH,     8'hA5, 1'b1, W_ERR},
        '{1'b0, F_START,    8'h00, 1'b1, W_OK},
        '{1'b0, F_START,    8'h00, 1'b1, W_ERR},
        '{1'b0, F_FINALIZE, 8'h00, 1'b1, W_OK},
        '{1'b0, F_POP,      8'h00, 1'b1, W_OK},
        '{1'b0, F_START,    8'h00, 1'b0, W_NONE},
        '{1'b0, F_PUSH,     8'h00, 1'b0, W_NONE},
        '{1'b0, F_PUSH,     8'hFF, 1'b0, W_NONE},
        '{1'b0, F_PUSH,     8'h5A, 1'b0, W_NONE},
        '{1'b0, F_FINALIZE, 8'h00, 1'b0, W_NONE},
        '{1'b0, F_START,    8'h00, 1'b0, W_NONE},
        '{1'b0, F_PUSH,     8'h3C, 1'b0, W_NONE},
        '{1'b0, F_ABORT,    8'h00, 1'b1, W_OK},
        '{1'b0, F_POP,      8'h00, 1'b0, W_NONE},
        '{1'b0, F_SPARE6,   8'hFF, 1'b1, W_OK},
        '{1'b0, F_SPARE7,   8'h00, 1'b1, W_OK},
        '{1'b0, F_START,    8'h00, 1'b0, W_NONE},
        '{1'b0, F_CLEAR,    8'h00, 1'b1, W_OK},
        '{1'b0, F_POP,      8'h00, 1'b1, W_EMPTY},
        '{1'b1, F_START,    8'd2,  1'b0, W_NONE},
        '{1'b0, F_START,    8'h00, 1'b1, W_OK},
        '{1'b0, F_PUSH,     8'h7E, 1'b1, W_OK},
        '{1'b0, F_PUSH,     8'h81, 1'b1, W_FULL},
        '{1'b0, F_FINALIZE, 8'h00, 1'b1, W_OK},
        '{1'b0, F_START,    8'h00, 1'b1, W_FULL},
        '{1'b0, F_POP,      8'h00, 1'b0, W_NONE}
    };

    localparam int PHASE_SIZE [0:NPHASES-1] = '{64, 2, 127, 5, 0, 17, 65};
    localparam int PHASE_IDLE [0:NPHASES-1] = '{0, 0, 52, 19, 52, 0, 19};

    logic             i_clk;
    logic             i_rst_n           = 1'b0;
    logic             start             = 1'b0;
    logic             busy;
    logic [2:0]       i_func            = F_START;
    logic [BW-1:0]    i_data_byte       = '0;
    logic             i_cfg_valid       = 1'b0;
    logic             o_cfg_ready;
    logic [CFG_W-1:0] i_cfg_buffer_size = CFG_W'(DEPTH);
    logic             o_valid;
    logic [1:0]       o_status;
    logic [BW-1:0]    o_out_byte;
    logic [LW-1:0]    o_packet_length;
    logic             o_last;

    logic             pin_fixed = 1'b0;
    t_fifo_word       pin_word  = '0;

    // Mirror of the ring
    logic [BW-1:0]    ring_bytes [DEPTH];
    logic [AW-1:0]    wr_ptr     = '0;
    logic [AW-1:0]    rd_ptr     = '0;
    logic [AW-1:0]    hdr_ptr    = '0;
    logic [LW-1:0]    pkt_len    = '0;
    logic             pkt_open   = 1'b0;
    int unsigned      bytes_held  = 0;
    int unsigned      bytes_ready = 0;
    logic [CFG_W-1:0] size_reg    = CFG_W'(DEPTH);

    t_fifo_word       expected_words [$];
    int               mismatch_count = 0;
    int               items_sent     = 0;
    int               words_checked  = 0;
    int               sizes_written  = 0;
    int               cycle_count    = 0;
    int               idle_pct       = 0;

    length_prefixed_packet_fifo u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_func            (i_func),
        .i_data_byte       (i_data_byte),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_buffer_size (i_cfg_buffer_size),
        .o_valid           (o_valid),
        .o_status          (o_status),
        .o_out_byte        (o_out_byte),
        .o_packet_length   (o_packet_length),
        .o_last            (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int unsigned ring_span();
        int unsigned s;
        s = size_reg;
        if (s < 2) begin
            s = 2;
        end else if (s > DEPTH) begin
            s = DEPTH;
        end
        return s;
    endfunction

    function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] p);
        return (int'(p) + 1 >= int'(ring_span())) ? '0 : p + 1'b1;
    endfunction

    task automatic empty_mirror();
        wr_ptr      = '0;
        rd_ptr      = '0;
        hdr_ptr     = '0;
        pkt_len     = '0;
        pkt_open    = 1'b0;
        bytes_held  = 0;
        bytes_ready = 0;
    endtask

    task automatic report_mismatch(input string msg);
        if (mismatch_count < 50) begin
            $display("%0t ns: %s", $time, msg);
        end
        mismatch_count++;
    endtask

    task automatic predict_words(input logic [2:0] f, input logic [BW-1:0] d);
        t_fifo_word  w;
        int unsigned n;
        int unsigned k;
        bit          popped;
        w      = W_OK;
        popped = 1'b0;
        case (f)
            F_START: begin
                if (pkt_open) begin
                    w.status = ST_ERR;
                end else if (bytes_held >= ring_span()) begin
                    w.status = ST_FULL;
                end else begin
                    hdr_ptr  = wr_ptr;
                    wr_ptr   = next_slot(wr_ptr);
                    bytes_held++;
                    pkt_len  = '0;
                    pkt_open = 1'b1;
                end
            end
            F_PUSH: begin
                if (!pkt_open) begin
                    w.status = ST_ERR;
                end else if (bytes_held >= ring_span()) begin
                    w.status = ST_FULL;
                end else begin
                    ring_bytes[wr_ptr] = d;
                    wr_ptr  = next_slot(wr_ptr);
                    bytes_held++;
                    pkt_len = pkt_len + 1'b1;
                end
            end
            F_FINALIZE: begin
                if (!pkt_open) begin
                    w.status = ST_ERR;
                end else begin
                    ring_bytes[hdr_ptr] = BW'(pkt_len);
                    bytes_ready += int'(pkt_len) + 1;
                    pkt_open = 1'b0;
                end
            end
            F_ABORT: begin
                if (!pkt_open) begin
                    w.status = ST_ERR;
                end else begin
                    wr_ptr = hdr_ptr;
                    bytes_held = (bytes_held >= int'(pkt_len) + 1) ?
                                 bytes_held - (int'(pkt_len) + 1) : 0;
                    pkt_open = 1'b0;
                    pkt_len  = '0;
                end
            end
            F_POP: begin
                if (bytes_ready == 0) begin
                    w.status = ST_EMPTY;
                end else begin
                    n = ring_bytes[rd_ptr][LW-1:0];
                    if (n > bytes_ready - 1) begin
                        n = bytes_ready - 1;
                    end
                    rd_ptr = next_slot(rd_ptr);
                    bytes_ready -= n + 1;
                    bytes_held = (bytes_held >= n + 1) ? bytes_held - (n + 1) : 0;
                    if (n != 0) begin
                        popped = 1'b1;
                        for (k = 0; k < n; k++) begin
                            w = '{ST_OK, ring_bytes[rd_ptr], LW'(n), (k + 1 == n)};
                            expected_words.push_back(w);
                            rd_ptr = next_slot(rd_ptr);
                        end
                    end
                end
            end
            F_CLEAR: begin
                empty_mirror();
            end
            default: begin
            end
        endcase
        if (!popped) begin
            expected_words.push_back(w);
        end
    endtask

    always @(posedge i_clk) begin
        t_fifo_word got;
        t_fifo_word want;
        cycle_count++;
        if (cycle_count == LIMIT) begin
            $display("Timeout after %0d cycles", LIMIT);
            $display("Mismatches found");
            $finish;
        end
        if (!i_rst_n) begin
            size_reg = CFG_W'(DEPTH);
            empty_mirror();
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                size_reg = i_cfg_buffer_size;
                empty_mirror();
            end
            if (start && !busy) begin
                predict_words(i_func, i_data_byte);
                if (pin_fixed) begin
                    expected_words[expected_words.size() - 1] = pin_word;
                end
            end
            if (o_valid) begin
                got = '{t_status'(o_status), o_out_byte, o_packet_length, o_last};
                words_checked++;
                if (expected_words.size() == 0) begin
                    report_mismatch($sformatf("unexpected word st=%0d byte=%02h len=%0d last=%0b",
                                              got.status, got.out_byte, got.pkt_length, got.last));
                end else begin
                    want = expected_words.pop_front();
                    if (got !== want) begin
                        report_mismatch($sformatf(
                            "got st=%0d byte=%02h len=%0d last=%0b, want st=%0d byte=%02h len=%0d last=%0b",
                            got.status, got.out_byte, got.pkt_length, got.last,
                            want.status, want.out_byte, want.pkt_length, want.last));
                    end
                end
            end
        end
    end

    task automatic send_word(input logic [2:0] f, input logic [BW-1:0] d,
                             input logic fixed, input t_fifo_word w);
        start       <= 1'b1;
        i_func      <= f;
        i_data_byte <= d;
        pin_fixed   <= fixed;
        pin_word    <= w;
        do @(posedge i_clk); while (busy);
        items_sent++;
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
    endtask

    task automatic drain_words();
        start <= 1'b0;
        @(posedge i_clk);
        while (expected_words.size() != 0 || busy) @(posedge i_clk);
    endtask

    task automatic write_ring_size(input logic [CFG_W-1:0] v);
        drain_words();
        repeat (2) @(posedge i_clk);
        i_cfg_buffer_size <= v;
        i_cfg_valid       <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sizes_written++;
    endtask

    task automatic send_packet(input int unsigned n, input bit may_abort);
        int unsigned k;
        send_word(F_START, BW'($urandom), 1'b0, W_NONE);
        for (k = 0; k < n; k++) begin
            send_word(F_PUSH, BW'($urandom), 1'b0, W_NONE);
        end
        if (may_abort && $urandom_range(0, 99) < 15) begin
            send_word(F_ABORT, BW'($urandom), 1'b0, W_NONE);
        end else begin
            send_word(F_FINALIZE, BW'($urandom), 1'b0, W_NONE);
        end
    endtask

    initial begin
        int          r;
        int          p;
        int          target;
        int unsigned len;
        logic [CFG_W-1:0] sz;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (r = 0; r < NROWS; r++) begin
            if (PLAN[r].cfg_write) begin
                write_ring_size(CFG_W'(PLAN[r].value));
            end else begin
                send_word(PLAN[r].func, PLAN[r].value, PLAN[r].fixed, PLAN[r].word);
            end
        end

        for (p = 0; p < NPHASES; p++) begin
            sz = (p == 5) ? CFG_W'($urandom_range(3, 63)) : CFG_W'(PHASE_SIZE[p]);
            write_ring_size(sz);
            idle_pct = PHASE_IDLE[p];
            if (p == 0) begin
                send_packet(ring_span() - 1, 1'b0);
                send_word(F_POP, BW'($urandom), 1'b0, W_NONE);
            end
            target = items_sent + 24;
            while (items_sent < target) begin
                r = $urandom_range(0, 99);
                if (r < 55) begin
                    len = ($urandom_range(0, 19) == 0) ? $urandom_range(0, ring_span())
                                                       : $urandom_range(0, 6);
                    send_packet(len, 1'b1);
                end else if (r < 85) begin
                    send_word(F_POP, BW'($urandom), 1'b0, W_NONE);
                end else if (r < 97) begin
                    send_word(3'($urandom_range(0, 7)), BW'($urandom), 1'b0, W_NONE);
                end else begin
                    send_word(F_CLEAR, BW'($urandom), 1'b0, W_NONE);
                end
            end
        end

        drain_words();
        repeat (8) @(posedge i_clk);
        if (expected_words.size() != 0) begin
            report_mismatch($sformatf("%0d words never seen", expected_words.size()));
        end
        $display("Sent %0d commands across %0d ring size settings, checked %0d result words",
                 items_sent, sizes_written, words_checked);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

### sim.f
design/lpf_pkg.sv
design/lpf_ram.sv
design/length_prefixed_packet_fifo.sv
verif/length_prefixed_packet_fifo_test.sv
